### hdl/fccb_pkg.sv
// Shared widths, constants, register indexes and sequencer states for
// four_cycle_count_bound_unit. No dependencies.
`timescale 1ns / 1ps

package fccb_pkg;

  // Field and register widths
  localparam int DEG_W      = 6;
  localparam int D2_W       = 11;
  localparam int N_W        = 7;
  localparam int E_W        = 11;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Working widths: g = n - d - 1 and h = e - d2, both signed
  localparam int G_W = 9;
  localparam int H_W = 12;

  // Serial divider: |4h^2 + g - 1| stays below 2^24, |g| below 2^7
  localparam int DIV_W     = 24;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int DEN_W     = 8;

  // Inverse of 3 modulo 2^32: exact division by 3 of a known multiple
  localparam logic [ACC_W-1:0] INV3 = 32'hAAAA_AAAB;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_MODE   = 2'd2;

  // Bound modes
  localparam logic MODE_LOWER = 1'b0;
  localparam logic MODE_UPPER = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_DEG0  = 20'h00002,  // d(d-1)
    S_DEG1  = 20'h00004,  // * (d-5)
    S_DEG2  = 20'h00008,  // / 6
    S_DEG3  = 20'h00010,  // add to signed sum, g(g-1)
    S_CUBE0 = 20'h00020,  // * (g-2)
    S_CUBE1 = 20'h00040,  // / 6
    S_CUBE2 = 20'h00080,  // h * k
    S_CUBE3 = 20'h00100,  // add to quarter sum, h*h
    S_EIG0  = 20'h00200,  // form numerator, start divider
    S_DIV   = 20'h00400,  // one quotient bit per cycle
    S_EIG1  = 20'h00800,  // sign fix, add to eighth sum
    S_FIN0  = 20'h01000,  // n(n-1)
    S_FIN1  = 20'h02000,  // * (n-2)
    S_FIN2  = 20'h04000,  // * (n-3)
    S_FIN3  = 20'h08000,  // / 24
    S_FIN4  = 20'h10000,  // e(e-1)
    S_FIN5  = 20'h20000,  // base + signed sum
    S_FIN6  = 20'h40000,  // + quarter term
    S_FIN7  = 20'h80000   // + eighth term, load output
  } state_t;

endpackage

### hdl/four_cycle_count_bound_unit.sv
// four_cycle_count_bound_unit: per-vertex accumulation and final bound.
// Depends on fccb_pkg (widths, constants, states).
//
// Each word runs the degree and cube steps and, in the lower mode, the
// bit-serial divider, skipped when the remaining vertex count is zero. The
// word marked last then runs the final steps. A word is taken only in idle.
// All products run through one registered 32x32 multiplier (low half).
// Result leaves through an output register; the next word is taken while it
// waits. Synchronous reset clears config, sums, out_valid and the sequencer.
`timescale 1ns / 1ps

module four_cycle_count_bound_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fccb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fccb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fccb_pkg::DEG_W-1:0]        degree,
  input  logic [fccb_pkg::D2_W-1:0]         second_degree,
  input  logic                              last_vertex,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fccb_pkg::ACC_W-1:0] cycle_bound
);

  localparam int AW = fccb_pkg::ACC_W;
  localparam int GW = fccb_pkg::G_W;
  localparam int HW = fccb_pkg::H_W;
  localparam int DW = fccb_pkg::DIV_W;
  localparam int NW = fccb_pkg::DEN_W;
  localparam int CW = fccb_pkg::DIV_CNT_W;

  fccb_pkg::state_t state;

  // configuration registers
  logic [fccb_pkg::N_W-1:0] vertex_count;
  logic [fccb_pkg::E_W-1:0] edge_count;
  logic                     bound_mode;

  // accumulators
  logic [AW-1:0] signed_sum;
  logic [AW-1:0] quarter_sum;
  logic [AW-1:0] eighth_sum;

  // per-word working registers
  logic [fccb_pkg::DEG_W-1:0] deg;
  logic signed [GW-1:0]       g;
  logic signed [HW-1:0]       h;
  logic                       last;
  logic [AW-1:0]              prod;
  logic [AW-1:0]              tmp;

  // divider registers
  logic [DW-1:0]                    quo;
  logic [NW-1:0]                    rem;
  logic [NW-1:0]                    den;
  logic                             qneg;
  logic [CW-1:0]                    div_cnt;

  // sign-extended operands
  logic [AW-1:0] d_x, g_x, h_x, n_x, e_x, k_x;
  logic [AW-1:0] mul_a, mul_b, mul_out;
  logic [AW-1:0] num, num_mag;
  logic [GW-1:0] g_mag;
  logic [NW-1:0] rem_sh;
  logic [AW-1:0] q_x;
  logic [AW-1:0] quarter_term, eighth_term;
  logic          in_acc;

  // registers change only between words
  assign cfg_ready = (state == fccb_pkg::S_IDLE);
  assign in_ready  = (state == fccb_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;

  assign d_x = AW'(deg);
  assign g_x = AW'(g);
  assign h_x = AW'(h);
  assign n_x = AW'(vertex_count);
  assign e_x = AW'(edge_count);

  // second factor of the h term: g-3 (lower) or g+2h-4 (upper)
  assign k_x = (bound_mode == fccb_pkg::MODE_UPPER) ? (g_x + (h_x << 1) - AW'(4))
                                                    : (g_x - AW'(3));

  // shared multiplier operand select
  always_comb begin
    mul_a = prod;
    mul_b = prod;
    unique case (state)
      fccb_pkg::S_DEG0:  begin mul_a = d_x; mul_b = d_x - AW'(1); end
      fccb_pkg::S_DEG1:  begin mul_a = prod; mul_b = d_x - AW'(5); end
      fccb_pkg::S_DEG2:  begin mul_a = AW'($signed(prod) >>> 1); mul_b = fccb_pkg::INV3; end
      fccb_pkg::S_DEG3:  begin mul_a = g_x; mul_b = g_x - AW'(1); end
      fccb_pkg::S_CUBE0: begin mul_a = prod; mul_b = g_x - AW'(2); end
      fccb_pkg::S_CUBE1: begin mul_a = AW'($signed(prod) >>> 1); mul_b = fccb_pkg::INV3; end
      fccb_pkg::S_CUBE2: begin mul_a = h_x; mul_b = k_x; end
      fccb_pkg::S_CUBE3: begin mul_a = h_x; mul_b = h_x; end
      fccb_pkg::S_FIN0:  begin mul_a = n_x; mul_b = n_x - AW'(1); end
      fccb_pkg::S_FIN1:  begin mul_a = prod; mul_b = n_x - AW'(2); end
      fccb_pkg::S_FIN2:  begin mul_a = prod; mul_b = n_x - AW'(3); end
      fccb_pkg::S_FIN3:  begin mul_a = prod >> 3; mul_b = fccb_pkg::INV3; end
      fccb_pkg::S_FIN4:  begin mul_a = e_x; mul_b = e_x - AW'(1); end
      default:           begin mul_a = prod; mul_b = prod; end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  // divider setup: numerator 4h^2 + g - 1, magnitudes and quotient sign
  assign num     = (prod << 2) + g_x - AW'(1);
  assign num_mag = num[AW-1] ? (-num) : num;
  assign g_mag   = g[GW-1] ? (-g) : g;

  // restoring divider step
  assign rem_sh = {rem[NW-2:0], quo[DW-1]};
  assign q_x    = qneg ? (-AW'(quo)) : AW'(quo);

  // final terms
  assign quarter_term = (bound_mode == fccb_pkg::MODE_UPPER) ? (quarter_sum >> 2)
                                                             : ((quarter_sum + AW'(3)) >> 2);
  assign eighth_term  = (bound_mode == fccb_pkg::MODE_UPPER) ? '0
                                                             : ((eighth_sum + AW'(7)) >> 3);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      edge_count   <= '0;
      bound_mode   <= fccb_pkg::MODE_LOWER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fccb_pkg::CFG_VERTEX_COUNT: vertex_count <= cfg_data[fccb_pkg::N_W-1:0];
        fccb_pkg::CFG_EDGE_COUNT:   edge_count   <= cfg_data[fccb_pkg::E_W-1:0];
        fccb_pkg::CFG_BOUND_MODE:   bound_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      deg  <= degree;
      last <= last_vertex;
      g    <= $signed({2'b00, vertex_count}) - $signed({3'b000, degree}) - 9'sd1;
      h    <= $signed({1'b0, edge_count}) - $signed({1'b0, second_degree});
    end
    unique case (state)
      fccb_pkg::S_CUBE2: tmp <= prod;
      fccb_pkg::S_FIN4:  tmp <= prod;
      fccb_pkg::S_FIN5:  tmp <= (prod >> 1) - tmp + signed_sum;
      fccb_pkg::S_FIN6:  tmp <= tmp + quarter_term;
      default: ;
    endcase
    prod <= mul_out;
    if (state == fccb_pkg::S_EIG0) begin
      quo     <= num_mag[DW-1:0];
      den     <= g_mag[NW-1:0];
      qneg    <= num[AW-1] ^ g[GW-1];
      rem     <= '0;
      div_cnt <= '0;
    end else if (state == fccb_pkg::S_DIV) begin
      div_cnt <= div_cnt + 1'b1;
      if (rem_sh >= den) begin
        rem <= rem_sh - den;
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  // sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fccb_pkg::S_IDLE;
      signed_sum  <= '0;
      quarter_sum <= '0;
      eighth_sum  <= '0;
      out_valid   <= 1'b0;
    end else begin
      // word taken with no new one loaded behind it
      if (out_valid && out_ready && state != fccb_pkg::S_FIN7) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        fccb_pkg::S_IDLE: begin
          if (in_acc) state <= fccb_pkg::S_DEG0;
        end
        fccb_pkg::S_DEG0:  state <= fccb_pkg::S_DEG1;
        fccb_pkg::S_DEG1:  state <= fccb_pkg::S_DEG2;
        fccb_pkg::S_DEG2:  state <= fccb_pkg::S_DEG3;
        fccb_pkg::S_DEG3: begin
          signed_sum <= signed_sum + prod;
          state      <= fccb_pkg::S_CUBE0;
        end
        fccb_pkg::S_CUBE0: state <= fccb_pkg::S_CUBE1;
        fccb_pkg::S_CUBE1: state <= fccb_pkg::S_CUBE2;
        fccb_pkg::S_CUBE2: state <= fccb_pkg::S_CUBE3;
        fccb_pkg::S_CUBE3: begin
          quarter_sum <= quarter_sum + tmp + prod;
          if (bound_mode == fccb_pkg::MODE_LOWER) begin
            state <= fccb_pkg::S_EIG0;
          end else begin
            state <= last ? fccb_pkg::S_FIN0 : fccb_pkg::S_IDLE;
          end
        end
        fccb_pkg::S_EIG0: begin
          // no remaining vertices: the eighth term adds nothing
          if (g == '0) begin
            state <= last ? fccb_pkg::S_FIN0 : fccb_pkg::S_IDLE;
          end else begin
            state <= fccb_pkg::S_DIV;
          end
        end
        fccb_pkg::S_DIV: begin
          if (div_cnt == CW'(DW - 1)) state <= fccb_pkg::S_EIG1;
        end
        fccb_pkg::S_EIG1: begin
          eighth_sum <= eighth_sum + q_x;
          state      <= last ? fccb_pkg::S_FIN0 : fccb_pkg::S_IDLE;
        end
        fccb_pkg::S_FIN0: state <= fccb_pkg::S_FIN1;
        fccb_pkg::S_FIN1: state <= fccb_pkg::S_FIN2;
        fccb_pkg::S_FIN2: state <= fccb_pkg::S_FIN3;
        fccb_pkg::S_FIN3: state <= fccb_pkg::S_FIN4;
        fccb_pkg::S_FIN4: state <= fccb_pkg::S_FIN5;
        fccb_pkg::S_FIN5: state <= fccb_pkg::S_FIN6;
        fccb_pkg::S_FIN6: state <= fccb_pkg::S_FIN7;
        fccb_pkg::S_FIN7: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            signed_sum  <= '0;
            quarter_sum <= '0;
            eighth_sum  <= '0;
            state       <= fccb_pkg::S_IDLE;
          end
        end
        default: state <= fccb_pkg::S_IDLE;
      endcase
    end
  end

  // output word, payload only
  always_ff @(posedge clk) begin
    if (state == fccb_pkg::S_FIN7 && (!out_valid || out_ready)) begin
      cycle_bound <= $signed(tmp + eighth_term);
    end
  end

endmodule
